// File: hw/rtl/wavhp_pkg.sv
// ----------------------------------------------------------------------------
// WAV header parser package
// Shared types, codes and tag constants of the WAV header parser.
// ----------------------------------------------------------------------------
package wavhp_pkg;

	// Result status codes, in the order in which the checks are made.
	typedef enum logic [2:0] {
		ST_OK,
		ST_BAD_HEADER,
		ST_NO_FMT,
		ST_NOT_PCM,
		ST_ZERO_FIELD,
		ST_NO_DATA,
		ST_UNSUPPORTED
	} status_t;

	// Phase of the header walk.
	typedef enum logic [1:0] {
		PH_RIFF,
		PH_CHDR,
		PH_BODY
	} ph_t;

	// Tags, first byte of the file in the lowest bits.
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	// Chunk ids as shifted in, first byte in the highest bits.
	localparam logic [23:0] ID_FMT3  = 24'h66_6D74;
	localparam logic [31:0] ID_DATA  = 32'h6461_7461;

	// Length of the RIFF/WAVE preamble and of the fmt fields captured.
	localparam logic [31:0] HDR_LEN  = 32'd12;
	localparam logic [4:0]  FMT_LEN  = 5'd16;

	// One input byte with its end-of-file mark.
	typedef struct packed {
		logic [7:0] file_byte;
		logic       is_last;
	} item_t;

	// One result.
	typedef struct packed {
		status_t     status;
		logic [1:0]  channels;
		logic [4:0]  bit_depth;
		logic [31:0] rate_hz;
		logic [31:0] frame_count;
		logic [31:0] data_start;
	} res_t;

endpackage

// File: hw/rtl/wavhp_parser.sv
// ----------------------------------------------------------------------------
// WAV header parser: chunk walker
// Holds the walk state, updates it for one byte per step and forms the
// result from the updated state when the byte closes the file.
// ----------------------------------------------------------------------------
module wavhp_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  wavhp_pkg::item_t item,
	output wavhp_pkg::res_t  res
);
	import wavhp_pkg::*;

	logic [31:0] byte_count_q, byte_count_n;
	logic        header_ok_q, header_ok_n;
	ph_t         phase_q, phase_n;
	logic [2:0]  hdr_idx_q, hdr_idx_n;
	logic [31:0] chunk_id_q, chunk_id_n;
	logic [31:0] chunk_length_q, chunk_length_n;
	logic [31:0] body_remaining_q, body_remaining_n;
	logic        in_fmt_q, in_fmt_n;
	logic [4:0]  fmt_got_q, fmt_got_n;
	logic [15:0] format_code_q, format_code_n;
	logic [15:0] channel_field_q, channel_field_n;
	logic [31:0] rate_field_q, rate_field_n;
	logic [15:0] depth_field_q, depth_field_n;
	logic        fmt_seen_q, fmt_seen_n;
	logic        data_seen_q, data_seen_n;
	logic [31:0] data_size_q, data_size_n;

	logic [7:0]  b;
	logic [3:0]  pos;
	logic [3:0]  off;
	status_t     status;
	logic [31:0] frames;

	assign b   = item.file_byte;
	assign pos = byte_count_q[3:0];
	assign off = fmt_got_q[3:0];

	// Walk state after the current byte.
	always_comb begin
		byte_count_n     = byte_count_q;
		header_ok_n      = header_ok_q;
		phase_n          = phase_q;
		hdr_idx_n        = hdr_idx_q;
		chunk_id_n       = chunk_id_q;
		chunk_length_n   = chunk_length_q;
		body_remaining_n = body_remaining_q;
		in_fmt_n         = in_fmt_q;
		fmt_got_n        = fmt_got_q;
		format_code_n    = format_code_q;
		channel_field_n  = channel_field_q;
		rate_field_n     = rate_field_q;
		depth_field_n    = depth_field_q;
		fmt_seen_n       = fmt_seen_q;
		data_seen_n      = data_seen_q;
		data_size_n      = data_size_q;

		case (phase_q)
			PH_RIFF: begin
				case (pos) inside
					[4'd0:4'd3]: begin
						if (b != TAG_RIFF[{pos[1:0], 3'b000} +: 8]) header_ok_n = 1'b0;
					end
					[4'd8:4'd11]: begin
						if (b != TAG_WAVE[{pos[1:0], 3'b000} +: 8]) header_ok_n = 1'b0;
					end
					default: ;
				endcase
				if (pos == 4'd11) begin
					phase_n   = PH_CHDR;
					hdr_idx_n = '0;
				end
			end
			PH_CHDR: begin
				if (!hdr_idx_q[2]) begin
					chunk_id_n = {chunk_id_q[23:0], b};
				end else begin
					chunk_length_n = {b, chunk_length_q[31:8]};
				end
				hdr_idx_n = hdr_idx_q + 3'd1;
				// The eighth header byte closes the chunk header.
				if (hdr_idx_q == 3'd7) begin
					in_fmt_n = 1'b0;
					if (!fmt_seen_q && chunk_id_q[31:8] == ID_FMT3) begin
						fmt_seen_n = 1'b1;
						in_fmt_n   = 1'b1;
						fmt_got_n  = '0;
					end else if (!data_seen_q && chunk_id_q == ID_DATA) begin
						data_seen_n = 1'b1;
						data_size_n = chunk_length_n;
					end
					body_remaining_n = chunk_length_n;
					if (chunk_length_n != '0) begin
						phase_n = PH_BODY;
					end else begin
						phase_n  = PH_CHDR;
						in_fmt_n = 1'b0;
					end
				end
			end
			PH_BODY: begin
				// Capture the fixed fields of the fmt body.
				if (in_fmt_q && fmt_got_q < FMT_LEN) begin
					case (off) inside
						[4'd0:4'd1]:   format_code_n[{off[0], 3'b000} +: 8] = b;
						[4'd2:4'd3]:   channel_field_n[{off[0], 3'b000} +: 8] = b;
						[4'd4:4'd7]:   rate_field_n[{off[1:0], 3'b000} +: 8] = b;
						[4'd14:4'd15]: depth_field_n[{off[0], 3'b000} +: 8] = b;
						default: ;
					endcase
					fmt_got_n = fmt_got_q + 5'd1;
				end
				body_remaining_n = body_remaining_q - 32'd1;
				if (body_remaining_q == 32'd1) begin
					phase_n   = PH_CHDR;
					hdr_idx_n = '0;
					in_fmt_n  = 1'b0;
				end
			end
			default: ;
		endcase

		if (byte_count_q != '1) byte_count_n = byte_count_q + 32'd1;
	end

	// Status by the order of the checks.
	always_comb begin
		if (byte_count_n < HDR_LEN || !header_ok_n) begin
			status = ST_BAD_HEADER;
		end else if (!fmt_seen_n) begin
			status = ST_NO_FMT;
		end else if (format_code_n != 16'd1) begin
			status = ST_NOT_PCM;
		end else if (channel_field_n == '0 || rate_field_n == '0 || depth_field_n == '0
				|| fmt_got_n < FMT_LEN) begin
			status = ST_ZERO_FIELD;
		end else if (!data_seen_n) begin
			status = ST_NO_DATA;
		end else if (channel_field_n > 16'd2
				|| (depth_field_n != 16'd8 && depth_field_n != 16'd16)) begin
			status = ST_UNSUPPORTED;
		end else begin
			status = ST_OK;
		end
	end

	// Frame count: bytes per sample and channel count are each one or two.
	always_comb begin
		frames = data_size_n;
		if (depth_field_n == 16'd16) frames = {1'b0, frames[31:1]};
		if (channel_field_n == 16'd2) frames = {1'b0, frames[31:1]};
	end

	// Result fields are zero unless the file is valid PCM.
	always_comb begin
		res        = '0;
		res.status = status;
		if (status == ST_OK) begin
			res.channels    = channel_field_n[1:0];
			res.bit_depth   = depth_field_n[4:0];
			res.rate_hz     = rate_field_n;
			res.frame_count = frames;
			res.data_start  = byte_count_n - data_size_n;
		end
	end

	// State update; the final byte of a file returns everything to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q     <= '0;
			header_ok_q      <= 1'b1;
			phase_q          <= PH_RIFF;
			hdr_idx_q        <= '0;
			chunk_id_q       <= '0;
			chunk_length_q   <= '0;
			body_remaining_q <= '0;
			in_fmt_q         <= 1'b0;
			fmt_got_q        <= '0;
			format_code_q    <= '0;
			channel_field_q  <= '0;
			rate_field_q     <= '0;
			depth_field_q    <= '0;
			fmt_seen_q       <= 1'b0;
			data_seen_q      <= 1'b0;
			data_size_q      <= '0;
		end else if (step && item.is_last) begin
			byte_count_q     <= '0;
			header_ok_q      <= 1'b1;
			phase_q          <= PH_RIFF;
			hdr_idx_q        <= '0;
			chunk_id_q       <= '0;
			chunk_length_q   <= '0;
			body_remaining_q <= '0;
			in_fmt_q         <= 1'b0;
			fmt_got_q        <= '0;
			format_code_q    <= '0;
			channel_field_q  <= '0;
			rate_field_q     <= '0;
			depth_field_q    <= '0;
			fmt_seen_q       <= 1'b0;
			data_seen_q      <= 1'b0;
			data_size_q      <= '0;
		end else if (step) begin
			byte_count_q     <= byte_count_n;
			header_ok_q      <= header_ok_n;
			phase_q          <= phase_n;
			hdr_idx_q        <= hdr_idx_n;
			chunk_id_q       <= chunk_id_n;
			chunk_length_q   <= chunk_length_n;
			body_remaining_q <= body_remaining_n;
			in_fmt_q         <= in_fmt_n;
			fmt_got_q        <= fmt_got_n;
			format_code_q    <= format_code_n;
			channel_field_q  <= channel_field_n;
			rate_field_q     <= rate_field_n;
			depth_field_q    <= depth_field_n;
			fmt_seen_q       <= fmt_seen_n;
			data_seen_q      <= data_seen_n;
			data_size_q      <= data_size_n;
		end
	end

	// The end of a file restarts the walk at the preamble.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.is_last |=> byte_count_q == '0 && phase_q == PH_RIFF)
		else $error("walk did not restart after the final byte");

	// Capturing fmt fields only happens inside the body of the first fmt chunk.
	a_in_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		in_fmt_q |-> fmt_seen_q && phase_q == PH_BODY)
		else $error("fmt capture active outside a fmt body");

	// The preamble phase covers only the first twelve bytes.
	a_riff_pos: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_RIFF |-> byte_count_q < HDR_LEN)
		else $error("preamble phase past offset eleven");

endmodule

// File: hw/rtl/wav_header_parser.sv
// ----------------------------------------------------------------------------
// WAV header parser
// Streams a WAV file byte by byte and reports one header check result per file.
// ----------------------------------------------------------------------------
// Usage:
//   The slave side takes one file byte per request in s_tdata, with s_tlast
//   high on the final byte of the file. Nothing comes out for other bytes.
//   For the final byte the master side presents one result: status and, for
//   valid PCM, channels, depth, rate, frame count and data offset.
//   Throughput is one byte per cycle unless a final byte waits on a stalled
//   output; the per-byte compare and counter update sit between the input
//   register and the walk state; each result is held in the output register.
//   When the receiver stalls, bytes keep flowing until a further final byte
//   reaches the input register, which then waits for the output register to
//   be taken. After the final byte the walk state returns to reset and the
//   next byte starts a new file. Reset empties both registers and clears the
//   walk state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module wav_header_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] file_byte
	input  logic         s_tlast,   // is_last
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata    // status, channels, bit_depth, rate_hz,
	                                // frame_count, data_start, zero fill
);
	import wavhp_pkg::*;

	logic  v_s1;
	item_t item_s1;
	logic  adv_s1;
	res_t  res;
	logic  out_v_q;
	res_t  out_q;

	// A non-final byte always advances; a final byte needs room for its result.
	assign adv_s1   = v_s1 && (!item_s1.is_last || !out_v_q || m_tready);
	assign s_tready = !v_s1 || adv_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.file_byte <= s_tdata;
			item_s1.is_last   <= s_tlast;
		end
	end

	wavhp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.item   (item_s1),
		.res    (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv_s1 && item_s1.is_last) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_s1.is_last) out_q <= res;
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {6'b0, out_q.data_start, out_q.frame_count, out_q.rate_hz,
		out_q.bit_depth, out_q.channels, out_q.status};

	// A result only lands in a free or draining output register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && item_s1.is_last |-> !out_v_q || m_tready)
		else $error("result written over a pending one");

	// Every final byte that advances yields a result in the next cycle.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && item_s1.is_last |=> m_tvalid)
		else $error("final byte produced no result");

	// Only a final byte facing a stalled output can hold the input register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv_s1 |-> item_s1.is_last && out_v_q && !m_tready)
		else $error("input register held without an output stall");

endmodule
